### sv/rsr_pkg.sv
package rsr_pkg;

  typedef logic [3:0] cmd_type_t;

  localparam cmd_type_t CMD_DRAW_LAST = 4'd3;
  localparam cmd_type_t CMD_RPASS     = 4'd4;
  localparam cmd_type_t CMD_VIEWPORT  = 4'd5;
  localparam cmd_type_t CMD_SCISSOR   = 4'd6;
  localparam cmd_type_t CMD_BLEND     = 4'd7;
  localparam cmd_type_t CMD_VERTEX    = 4'd8;
  localparam cmd_type_t CMD_INDEX     = 4'd9;
  localparam cmd_type_t CMD_PIPELINE  = 4'd10;
  localparam cmd_type_t CMD_CONSTANT  = 4'd11;
  localparam cmd_type_t CMD_SAMPLER   = 4'd12;
  localparam cmd_type_t CMD_TEXTURE   = 4'd13;
  localparam cmd_type_t CMD_RTARGET   = 4'd14;

  localparam int NSINGLE   = 5;
  localparam int SLOTS_DEF = 8;
  localparam int HANDLE_W  = 16;

  // Replay order of the slotless kinds.
  function automatic cmd_type_t single_code(input logic [2:0] idx);
    cmd_type_t t;
    case (idx)
      3'd0:    t = CMD_PIPELINE;
      3'd1:    t = CMD_VIEWPORT;
      3'd2:    t = CMD_SCISSOR;
      3'd3:    t = CMD_BLEND;
      default: t = CMD_INDEX;
    endcase
    return t;
  endfunction

  function automatic cmd_type_t group_code(input logic [1:0] grp);
    cmd_type_t t;
    case (grp)
      2'd0:    t = CMD_VERTEX;
      2'd1:    t = CMD_CONSTANT;
      2'd2:    t = CMD_SAMPLER;
      default: t = CMD_TEXTURE;
    endcase
    return t;
  endfunction

endpackage

### sv/rsr_cmd_if.sv
interface rsr_cmd_if import rsr_pkg::*; ();
  logic                valid;
  logic                ready;
  cmd_type_t           command_type;
  logic [2:0]          slot;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, command_type, slot, handle, input ready);
  modport sink (input valid, command_type, slot, handle, output ready);
endinterface

### sv/rsr_res_if.sv
interface rsr_res_if import rsr_pkg::*; ();
  logic                valid;
  logic                ready;
  cmd_type_t           out_type;
  logic [2:0]          out_slot;
  logic [HANDLE_W-1:0] out_handle;
  logic                is_replay;
  logic                last;

  modport source (output valid, out_type, out_slot, out_handle, is_replay, last,
                  input ready);
  modport sink (input valid, out_type, out_slot, out_handle, is_replay, last,
                output ready);
endinterface

### sv/rsr_ram.sv
module rsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/render_state_replay_on_pass_change.sv
// Output: results leave through one output register. An ordinary command is offered in the
// cycle after its transfer; the first replay of a flushing draw waits until the walk has begun.
// Throughput: ordinary commands go one per cycle while the output is free. The first draw after
// reset or a render pass then holds the input off while the walk visits each slotless kind and
// slotted entry, reads the handle memory per slotted replay, sends the draw, and waits out stalls.
// Reset: all entries invalid and not stale, flush armed, output register empty.
module render_state_replay_on_pass_change import rsr_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rsr_cmd_if.sink   cmd_i,
  rsr_res_if.source res_o
);

  // Slotted entries are grouped vertex, constant, sampler, texture, each SLOTS long.
  localparam int NSLOT = 4 * SLOTS;
  localparam int EW    = $clog2(NSLOT);
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SNGL = 3'd1;
  localparam logic [2:0] ST_SLOT = 3'd2;
  localparam logic [2:0] ST_RDAT = 3'd3;
  localparam logic [2:0] ST_DRAW = 3'd4;

  logic [2:0] state_q, state_d;

  // Remembered state. Handles of slotless kinds live in flops; slotted handles live
  // in a small memory. Valid and stale bits are flops so that a render pass can mark
  // everything stale at once.
  logic [HANDLE_W-1:0] single_h_q [NSINGLE];
  logic [NSINGLE-1:0]  single_valid_q, single_valid_d;
  logic [NSINGLE-1:0]  single_stale_q, single_stale_d;
  logic [NSLOT-1:0]    slot_valid_q, slot_valid_d;
  logic [NSLOT-1:0]    slot_stale_q, slot_stale_d;
  logic [SLOTS-1:0]    tex_kind_q;
  logic                flush_q, flush_d;

  // Walk counters: single index, flat slotted index, and its group and slot.
  logic [2:0]    sidx_q, sidx_d;
  logic [EW-1:0] e_q, e_d;
  logic [1:0]    grp_q, grp_d;
  logic [SW-1:0] sl_q, sl_d;

  // Draw held back while the replays go out.
  cmd_type_t           draw_type_q;
  logic [HANDLE_W-1:0] draw_h_q;

  // Output register.
  logic                out_valid_q, out_valid_d;
  cmd_type_t           out_type_q, out_type_d;
  logic [2:0]          out_slot_q, out_slot_d;
  logic [HANDLE_W-1:0] out_h_q, out_h_d;
  logic                out_rep_q, out_rep_d;
  logic                out_last_q, out_last_d;

  logic out_free;
  logic acc;

  // Decoded input command.
  logic          in_single;
  logic [2:0]    in_sidx;
  logic          in_slotted;
  logic [1:0]    in_grp;
  logic          in_slot_ok;
  logic [EW-1:0] in_addr;

  // Handle memory ports.
  logic                ram_we;
  logic                ram_re;
  logic [HANDLE_W-1:0] ram_rdata;

  // The output register is free when it is empty or its content is taken this cycle.
  assign out_free  = !out_valid_q || res_o.ready;
  assign cmd_i.ready = (state_q == ST_IDLE) && out_free;
  assign acc       = cmd_i.valid && cmd_i.ready;

  always_comb begin
    in_single  = 1'b0;
    in_sidx    = 3'd0;
    in_slotted = 1'b0;
    in_grp     = 2'd0;
    case (cmd_i.command_type)
      CMD_PIPELINE: begin in_single = 1'b1; in_sidx = 3'd0; end
      CMD_VIEWPORT: begin in_single = 1'b1; in_sidx = 3'd1; end
      CMD_SCISSOR:  begin in_single = 1'b1; in_sidx = 3'd2; end
      CMD_BLEND:    begin in_single = 1'b1; in_sidx = 3'd3; end
      CMD_INDEX:    begin in_single = 1'b1; in_sidx = 3'd4; end
      CMD_VERTEX:   begin in_slotted = 1'b1; in_grp = 2'd0; end
      CMD_CONSTANT: begin in_slotted = 1'b1; in_grp = 2'd1; end
      CMD_SAMPLER:  begin in_slotted = 1'b1; in_grp = 2'd2; end
      CMD_TEXTURE:  begin in_slotted = 1'b1; in_grp = 2'd3; end
      CMD_RTARGET:  begin in_slotted = 1'b1; in_grp = 2'd3; end
      default: begin
        in_single  = 1'b0;
        in_slotted = 1'b0;
      end
    endcase
  end

  // A slot beyond the configured count passes through but is not remembered.
  assign in_slot_ok = (32'(cmd_i.slot) < SLOTS);
  assign in_addr    = EW'(32'(in_grp) * SLOTS + 32'(cmd_i.slot));
  assign ram_we     = acc && in_slotted && in_slot_ok;

  always_comb begin
    state_d        = state_q;
    single_valid_d = single_valid_q;
    single_stale_d = single_stale_q;
    slot_valid_d   = slot_valid_q;
    slot_stale_d   = slot_stale_q;
    flush_d        = flush_q;
    sidx_d         = sidx_q;
    e_d            = e_q;
    grp_d          = grp_q;
    sl_d           = sl_q;
    ram_re         = 1'b0;

    out_valid_d = out_valid_q && !res_o.ready;
    out_type_d  = out_type_q;
    out_slot_d  = out_slot_q;
    out_h_d     = out_h_q;
    out_rep_d   = out_rep_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          // Pass-through copy; a flushing draw is held back until the replays end.
          out_valid_d = 1'b1;
          out_type_d  = cmd_i.command_type;
          out_slot_d  = in_slotted ? cmd_i.slot : 3'd0;
          out_h_d     = cmd_i.handle;
          out_rep_d   = 1'b0;
          out_last_d  = 1'b1;

          if (cmd_i.command_type == CMD_RPASS) begin
            single_stale_d = single_stale_q | single_valid_q;
            slot_stale_d   = slot_stale_q | slot_valid_q;
            flush_d        = 1'b1;
          end
          if (in_single) begin
            single_valid_d[in_sidx] = 1'b1;
            single_stale_d[in_sidx] = 1'b0;
          end
          if (in_slotted && in_slot_ok) begin
            slot_valid_d[in_addr] = 1'b1;
            slot_stale_d[in_addr] = 1'b0;
          end
          if ((cmd_i.command_type <= CMD_DRAW_LAST) && flush_q) begin
            out_valid_d = out_valid_q && !res_o.ready;
            flush_d     = 1'b0;
            sidx_d      = 3'd0;
            state_d     = ST_SNGL;
          end
        end
      end

      ST_SNGL: begin
        if (!(single_valid_q[sidx_q] && single_stale_q[sidx_q]) || out_free) begin
          if (single_valid_q[sidx_q] && single_stale_q[sidx_q]) begin
            out_valid_d = 1'b1;
            out_type_d  = single_code(sidx_q);
            out_slot_d  = 3'd0;
            out_h_d     = single_h_q[sidx_q];
            out_rep_d   = 1'b1;
            out_last_d  = 1'b0;
          end
          if (sidx_q == 3'(NSINGLE - 1)) begin
            e_d     = '0;
            grp_d   = 2'd0;
            sl_d    = '0;
            state_d = ST_SLOT;
          end else begin
            sidx_d = sidx_q + 3'd1;
          end
        end
      end

      ST_SLOT, ST_RDAT: begin
        if (state_q == ST_SLOT && slot_valid_q[e_q] && slot_stale_q[e_q]) begin
          // Fetch the handle; ST_RDAT emits it once the output register is free.
          ram_re  = 1'b1;
          state_d = ST_RDAT;
        end else if (state_q == ST_SLOT || out_free) begin
          if (state_q == ST_RDAT) begin
            out_valid_d = 1'b1;
            out_type_d  = (grp_q == 2'd3 && tex_kind_q[sl_q]) ? CMD_RTARGET
                                                             : group_code(grp_q);
            out_slot_d  = 3'(sl_q);
            out_h_d     = ram_rdata;
            out_rep_d   = 1'b1;
            out_last_d  = 1'b0;
          end
          if (e_q == EW'(NSLOT - 1)) begin
            state_d = ST_DRAW;
          end else begin
            state_d = ST_SLOT;
            e_d     = e_q + 1'b1;
            if (sl_q == SW'(SLOTS - 1)) begin
              sl_d  = '0;
              grp_d = grp_q + 2'd1;
            end else begin
              sl_d = sl_q + 1'b1;
            end
          end
        end
      end

      ST_DRAW: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_type_d  = draw_type_q;
          out_slot_d  = 3'd0;
          out_h_d     = draw_h_q;
          out_rep_d   = 1'b0;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  rsr_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (NSLOT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_addr),
    .wdata_i (cmd_i.handle),
    .re_i    (ram_re),
    .raddr_i (e_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      single_valid_q <= '0;
      single_stale_q <= '0;
      slot_valid_q   <= '0;
      slot_stale_q   <= '0;
      flush_q        <= 1'b1;
      sidx_q         <= 3'd0;
      e_q            <= '0;
      grp_q          <= 2'd0;
      sl_q           <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      single_valid_q <= single_valid_d;
      single_stale_q <= single_stale_d;
      slot_valid_q   <= slot_valid_d;
      slot_stale_q   <= slot_stale_d;
      flush_q        <= flush_d;
      sidx_q         <= sidx_d;
      e_q            <= e_d;
      grp_q          <= grp_d;
      sl_q           <= sl_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    out_type_q <= out_type_d;
    out_slot_q <= out_slot_d;
    out_h_q    <= out_h_d;
    out_rep_q  <= out_rep_d;
    out_last_q <= out_last_d;
    if (acc) begin
      draw_type_q <= cmd_i.command_type;
      draw_h_q    <= cmd_i.handle;
      if (in_single) begin
        single_h_q[in_sidx] <= cmd_i.handle;
      end
      if (in_slotted && in_slot_ok && in_grp == 2'd3) begin
        tex_kind_q[SW'(cmd_i.slot)] <= (cmd_i.command_type == CMD_RTARGET);
      end
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.out_type   = out_type_q;
  assign res_o.out_slot   = out_slot_q;
  assign res_o.out_handle = out_h_q;
  assign res_o.is_replay  = out_rep_q;
  assign res_o.last       = out_last_q;

  // A draw that consumes the armed flush always starts the walk.
  a_flush_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (cmd_i.command_type <= CMD_DRAW_LAST) && flush_q |=> state_q == ST_SNGL)
    else $error("flushing draw did not start the replay walk");

  // A replayed copy is never the final result of its command.
  a_replay_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.is_replay |-> !res_o.last)
    else $error("replay marked as last");

  // Stale is only ever set on a valid entry.
  a_stale_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((slot_stale_q & ~slot_valid_q) == '0) && ((single_stale_q & ~single_valid_q) == '0))
    else $error("stale entry without valid");

  // The flush flag is never armed while a walk is under way.
  a_walk_no_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !flush_q)
    else $error("flush armed during walk");

endmodule

### sim/render_state_replay_on_pass_change_tb.sv
`timescale 1ns / 100ps

module render_state_replay_on_pass_change_tb;
  import rsr_pkg::*;

  localparam int SLOTS          = SLOTS_DEF;
  // The sender and the receiver each take a turn off in about this many cycles of a hundred.
  localparam int IDLE_PCT       = 12;
  // The long receiver hold-off, counted in cycles by the receiver itself.
  localparam int HOLD_CYCLES    = 150;
  // Cycles without any transfer on either channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 1000;
  // Quiet cycles after the last expected result, to catch anything spurious.
  localparam int DRAIN_CYCLES   = 40;

  // Codes that the package does not name: the first draw and the unused type fifteen.
  localparam cmd_type_t CMD_DRAW_FIRST = 4'd0;
  localparam cmd_type_t CMD_RESERVED   = 4'd15;
  localparam int        NUM_KINDS      = 16;
  localparam int        NUM_STATE_KINDS = 10;

  typedef struct packed {
    cmd_type_t           kind;
    logic [2:0]          slot;
    logic [HANDLE_W-1:0] handle;
    logic                replay;
    logic                last;
  } emitted_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  rsr_cmd_if cmd_bus ();
  rsr_res_if res_bus ();

  render_state_replay_on_pass_change #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_bus),
    .res_o (res_bus)
  );

  always #1 clk_i = ~clk_i;

  // Replay order: the slotless kinds first, then every slot of each slotted group.
  cmd_type_t single_order [NSINGLE] = '{CMD_PIPELINE, CMD_VIEWPORT, CMD_SCISSOR, CMD_BLEND,
                                        CMD_INDEX};
  cmd_type_t group_order [4] = '{CMD_VERTEX, CMD_CONSTANT, CMD_SAMPLER, CMD_TEXTURE};
  cmd_type_t state_kinds [NUM_STATE_KINDS] = '{CMD_PIPELINE, CMD_VIEWPORT, CMD_SCISSOR,
                                               CMD_BLEND, CMD_INDEX, CMD_VERTEX, CMD_CONSTANT,
                                               CMD_SAMPLER, CMD_TEXTURE, CMD_RTARGET};

  // Shadow of the remembered render state. Both stores are indexed by the command type, so
  // that the texture group is kept under CMD_TEXTURE whether the command was a texture or a
  // render target; the latter is recorded separately per slot.
  logic [HANDLE_W-1:0] single_handle [NUM_KINDS];
  logic                single_valid  [NUM_KINDS];
  logic                single_stale  [NUM_KINDS];
  logic [HANDLE_W-1:0] slot_handle   [NUM_KINDS][SLOTS];
  logic                slot_valid    [NUM_KINDS][SLOTS];
  logic                slot_stale    [NUM_KINDS][SLOTS];
  logic                tex_is_target [SLOTS];
  logic                flush_armed;

  // Commands that the block is still to emit, oldest first.
  emitted_cmd_t expected_stream [$];

  int errors       = 0;
  int idle_pct     = IDLE_PCT;
  int holds_asked  = 0;
  int holds_served = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  task automatic clear_render_state();
    for (int k = 0; k < NUM_KINDS; k++) begin
      single_handle[k] = '0;
      single_valid[k]  = 1'b0;
      single_stale[k]  = 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        slot_handle[k][s] = '0;
        slot_valid[k][s]  = 1'b0;
        slot_stale[k][s]  = 1'b0;
      end
    end
    for (int s = 0; s < SLOTS; s++) tex_is_target[s] = 1'b0;
    flush_armed = 1'b1;
  endtask

  function automatic void queue_emitted(input cmd_type_t kind, input logic [2:0] slot,
                                        input logic [HANDLE_W-1:0] handle,
                                        input logic replay, input logic last);
    emitted_cmd_t e;
    e.kind   = kind;
    e.slot   = slot;
    e.handle = handle;
    e.replay = replay;
    e.last   = last;
    expected_stream = {expected_stream, e};
  endfunction

  // Updates the shadow state for one accepted command and queues the commands it causes:
  // the replays of any stale state when it is the first draw after a render pass, and then
  // the command itself.
  task automatic predict_replay(input cmd_type_t kind, input logic [2:0] slot,
                                input logic [HANDLE_W-1:0] handle);
    cmd_type_t group;
    cmd_type_t replay_kind;
    logic      slotted;
    slotted = 1'b0;
    group   = kind;
    case (kind)
      CMD_RPASS: begin
        // Everything remembered so far goes stale, and the next draw must flush it.
        for (int k = 0; k < NUM_KINDS; k++) begin
          if (single_valid[k]) single_stale[k] = 1'b1;
          for (int s = 0; s < SLOTS; s++)
            if (slot_valid[k][s]) slot_stale[k][s] = 1'b1;
        end
        flush_armed = 1'b1;
      end
      CMD_PIPELINE, CMD_VIEWPORT, CMD_SCISSOR, CMD_BLEND, CMD_INDEX: begin
        single_handle[kind] = handle;
        single_valid[kind]  = 1'b1;
        single_stale[kind]  = 1'b0;
      end
      CMD_VERTEX, CMD_CONSTANT, CMD_SAMPLER, CMD_TEXTURE, CMD_RTARGET: begin
        slotted = 1'b1;
        if (kind == CMD_RTARGET) group = CMD_TEXTURE;
        if (slot < SLOTS) begin
          slot_handle[group][slot] = handle;
          slot_valid[group][slot]  = 1'b1;
          slot_stale[group][slot]  = 1'b0;
          if (group == CMD_TEXTURE) tex_is_target[slot] = (kind == CMD_RTARGET);
        end
      end
      default: begin
        // A draw uses up the pending flush even when nothing is stale. Entries stay stale
        // afterwards; only a fresh write clears that.
        if (kind <= CMD_DRAW_LAST && flush_armed) begin
          foreach (single_order[i])
            if (single_valid[single_order[i]] && single_stale[single_order[i]])
              queue_emitted(single_order[i], 3'd0, single_handle[single_order[i]],
                            1'b1, 1'b0);
          foreach (group_order[g])
            for (int s = 0; s < SLOTS; s++)
              if (slot_valid[group_order[g]][s] && slot_stale[group_order[g]][s]) begin
                replay_kind = group_order[g];
                if (replay_kind == CMD_TEXTURE && tex_is_target[s]) replay_kind = CMD_RTARGET;
                queue_emitted(replay_kind, 3'(s), slot_handle[group_order[g]][s],
                              1'b1, 1'b0);
              end
          flush_armed = 1'b0;
        end
      end
    endcase
    // The command itself closes the burst; slotless kinds carry slot zero.
    queue_emitted(kind, slotted ? slot : 3'd0, handle, 1'b0, 1'b1);
  endtask

  // Offers one command, after a random gap, and holds it until the block takes it. The
  // valid stays high on return, so that a following command offered without a gap keeps it up.
  task automatic send_cmd(input cmd_type_t kind, input logic [2:0] slot,
                          input logic [HANDLE_W-1:0] handle);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      cmd_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    cmd_bus.valid        = 1'b1;
    cmd_bus.command_type = kind;
    cmd_bus.slot         = slot;
    cmd_bus.handle       = handle;
    @(posedge clk_i);
    while (!cmd_bus.ready) @(posedge clk_i);
    predict_replay(kind, slot, handle);
  endtask

  task automatic send_random_state();
    send_cmd(state_kinds[$urandom_range(0, NUM_STATE_KINDS - 1)], 3'($urandom_range(0, 7)),
             16'($urandom_range(0, 65535)));
  endtask

  // Frames as a renderer issues them: a render pass, some state, then one to three draws.
  // Some frames are broken on purpose (no render pass, or no draw), and some draws are
  // replaced by a command of any type, type fifteen included.
  task automatic send_frames(input int n_items);
    int sent;
    int roll;
    int n_state;
    int n_draw;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll >= 10) begin
        send_cmd(CMD_RPASS, 3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
        sent++;
      end
      n_state = $urandom_range(0, 8);
      repeat (n_state) begin
        send_random_state();
        sent++;
      end
      n_draw = (roll >= 10 && roll < 20) ? 0 : $urandom_range(1, 3);
      repeat (n_draw) begin
        if ($urandom_range(0, 99) < 10)
          send_cmd(cmd_type_t'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                   16'($urandom_range(0, 65535)));
        else
          send_cmd(cmd_type_t'($urandom_range(CMD_DRAW_FIRST, CMD_DRAW_LAST)),
                   3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
        sent++;
      end
    end
  endtask

  // Hand-picked commands: field extremes, every kind, a draw before any render pass, the
  // unused type, slots on slotless kinds, state set after a pass, a repeated draw, a texture
  // slot switching from render target back to texture, and two passes in a row.
  task automatic test_directed_cases();
    send_cmd(CMD_DRAW_LAST, 3'd7, 16'hFFFF);
    send_cmd(CMD_RESERVED,  3'd5, 16'h1234);
    send_cmd(CMD_PIPELINE,  3'd7, 16'hFFFF);
    send_cmd(CMD_VIEWPORT,  3'd2, 16'h0000);
    send_cmd(CMD_SCISSOR,   3'd0, 16'h8001);
    send_cmd(CMD_BLEND,     3'd1, 16'h7FFE);
    send_cmd(CMD_INDEX,     3'd6, 16'h00FF);
    send_cmd(CMD_VERTEX,    3'd0, 16'h0000);
    send_cmd(CMD_CONSTANT,  3'd7, 16'hFFFF);
    send_cmd(CMD_SAMPLER,   3'd3, 16'h5A5A);
    send_cmd(CMD_TEXTURE,   3'd0, 16'hA5A5);
    send_cmd(CMD_RTARGET,   3'd7, 16'hC3C3);
    send_cmd(CMD_RPASS,     3'd7, 16'hFFFF);
    send_cmd(CMD_BLEND,     3'd4, 16'h1111);
    send_cmd(CMD_DRAW_FIRST, 3'd2, 16'h0001);
    send_cmd(CMD_DRAW_LAST, 3'd0, 16'h0002);
    send_cmd(CMD_RPASS,     3'd0, 16'h0000);
    send_cmd(CMD_TEXTURE,   3'd7, 16'hFFFE);
    send_cmd(CMD_RPASS,     3'd3, 16'h4444);
    send_cmd(CMD_RPASS,     3'd4, 16'h8888);
    send_cmd(CMD_DRAW_FIRST, 3'd7, 16'hFFFF);
    send_cmd(CMD_RESERVED,  3'd0, 16'h0000);
  endtask

  task automatic test_random_frames();
    idle_pct = IDLE_PCT;
    send_frames(25);
  endtask

  // Neither side pauses here, so the block runs at its full rate.
  task automatic test_full_rate();
    idle_pct = 0;
    send_frames(12);
    idle_pct = IDLE_PCT;
  endtask

  // Every entry is written, a render pass makes them all stale, and the receiver then holds
  // off for a long stretch while the flushing draw and the commands after it are offered.
  // The draw produces the longest possible burst and the block has to stall its input.
  task automatic test_receiver_holdoff();
    foreach (single_order[i]) send_cmd(single_order[i], 3'd0, 16'($urandom_range(0, 65535)));
    foreach (group_order[g])
      for (int s = 0; s < SLOTS; s++)
        send_cmd((group_order[g] == CMD_TEXTURE && $urandom_range(0, 1)) ? CMD_RTARGET
                                                                           : group_order[g],
                 3'(s), 16'($urandom_range(0, 65535)));
    send_cmd(CMD_RPASS, 3'd1, 16'h0F0F);
    holds_asked++;
    send_cmd(CMD_DRAW_FIRST, 3'd5, 16'hF0F0);
    send_frames(4);
  endtask

  // Receiver: random pauses, plus the long hold-off whenever a test asks for one.
  always @(negedge clk_i) begin
    if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_bus.ready = 1'b0;
    end else begin
      res_bus.ready = ($urandom_range(0, 99) >= idle_pct);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Each transfer on the result channel is matched against the oldest expected command.
  always @(posedge clk_i) begin
    emitted_cmd_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (expected_stream.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual type %0h slot %0h handle %0h",
                 $time, res_bus.out_type, res_bus.out_slot, res_bus.out_handle);
      end else begin
        want = expected_stream.pop_front();
        check_field("out_type",   32'(want.kind),   32'(res_bus.out_type));
        check_field("out_slot",   32'(want.slot),   32'(res_bus.out_slot));
        check_field("out_handle", 32'(want.handle), 32'(res_bus.out_handle));
        check_field("is_replay",  32'(want.replay), 32'(res_bus.is_replay));
        check_field("last",       32'(want.last),   32'(res_bus.last));
      end
    end
  end

  // Watchdog: a long run of cycles with no transfer on either channel means a hang.
  always @(posedge clk_i) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni               = 1'b0;
    cmd_bus.valid        = 1'b0;
    cmd_bus.command_type = CMD_DRAW_FIRST;
    cmd_bus.slot         = 3'd0;
    cmd_bus.handle       = '0;
    clear_render_state();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_random_frames();
    test_full_rate();
    test_receiver_holdoff();

    @(negedge clk_i);
    cmd_bus.valid = 1'b0;
    // The watchdog bounds both waits below.
    while (expected_stream.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
